FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the color conversion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge; skipped while reset is asserted.
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Stage payload types and sector codes for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Hue sectors, 60 degrees each.
    localparam logic [2:0] SEC_RED_YEL  = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [2:0] SEC_MAG_RED  = 3'd5;

    localparam logic [16:0] FULL_TURN = 17'd65536;
    localparam logic [8:0]  Q8_ONE    = 9'd256;

    // Reciprocal of 60 scaled by 2^20, rounded up; exact for products below 15361.
    localparam logic [14:0] RECIP_60   = 15'd17477;
    localparam int          RECIP_SHFT = 20;

    typedef struct packed {
        logic [8:0] h;
        logic [8:0] c;
        logic [8:0] v;
    } t_s1;

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] w;
        logic [8:0] c;
        logic [8:0] m;
    } t_s2;

    typedef struct packed {
        logic [2:0]  sector;
        logic [13:0] prod;
        logic [8:0]  c;
        logic [8:0]  m;
    } t_s3;

    typedef struct packed {
        logic [2:0] sector;
        logic [8:0] x;
        logic [8:0] c;
        logic [8:0] m;
    } t_s4;

endpackage

FILE: hdl/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// First stage: clamps the inputs, scales the hue to degrees and forms chroma.
// ----------------------------------------------------------------------------
module hsv2rgb_front
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [16:0] i_hue_turn,
    input  logic [8:0]  i_saturation,
    input  logic [8:0]  i_brightness,
    output logic        o_valid,
    output t_s1         o_data
);

    logic        r_valid;
    t_s1         r_data;
    t_s1         n_data;
    logic [16:0] hue_c;
    logic [8:0]  sat_c;
    logic [8:0]  val_c;
    logic [25:0] hue_deg;
    logic [17:0] sv_prod;

    always_comb begin
        hue_c   = (i_hue_turn > FULL_TURN) ? FULL_TURN : i_hue_turn;
        sat_c   = (i_saturation > Q8_ONE) ? Q8_ONE : i_saturation;
        val_c   = (i_brightness > Q8_ONE) ? Q8_ONE : i_brightness;
        hue_deg = 26'(hue_c) * 26'd360;
        sv_prod = 18'(sat_c) * 18'(val_c);
        n_data.h = hue_deg[24:16];
        n_data.c = sv_prod[16:8];
        n_data.v = val_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Second stage: finds the hue sector, the secondary weight and the offset m.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s1  i_data,
    output logic o_valid,
    output t_s2  o_data
);

    logic       r_valid;
    t_s2        r_data;
    t_s2        n_data;
    logic [8:0] hm;

    always_comb begin
        // Hue modulo 120 by range; 360 wraps to zero.
        if (i_data.h >= 9'd360) begin
            hm = i_data.h - 9'd360;
        end else if (i_data.h >= 9'd240) begin
            hm = i_data.h - 9'd240;
        end else if (i_data.h >= 9'd120) begin
            hm = i_data.h - 9'd120;
        end else begin
            hm = i_data.h;
        end

        if (i_data.h < 9'd60) begin
            n_data.sector = SEC_RED_YEL;
        end else if (i_data.h < 9'd120) begin
            n_data.sector = SEC_YEL_GRN;
        end else if (i_data.h < 9'd180) begin
            n_data.sector = SEC_GRN_CYN;
        end else if (i_data.h < 9'd240) begin
            n_data.sector = SEC_CYN_BLU;
        end else if (i_data.h < 9'd300) begin
            n_data.sector = SEC_BLU_MAG;
        end else begin
            n_data.sector = SEC_MAG_RED;
        end

        // Weight is 60 minus the distance from the sector edge.
        n_data.w = (hm >= 9'd60) ? 6'(9'd120 - hm) : hm[5:0];
        n_data.c = i_data.c;
        n_data.m = i_data.v - i_data.c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/hsv2rgb_xdiv.sv
// ----------------------------------------------------------------------------
// hsv2rgb_xdiv
// Third and fourth stages: secondary component X = floor(C * w / 60).
// ----------------------------------------------------------------------------
module hsv2rgb_xdiv
    import hsv2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s2  i_data,
    output logic o_valid,
    output t_s4  o_data
);

    logic        r_valid3;
    logic        r_valid4;
    t_s3         r_s3;
    t_s3         n_s3;
    t_s4         r_s4;
    t_s4         n_s4;
    logic [14:0] cw_prod;
    logic [28:0] q_prod;

    always_comb begin
        cw_prod       = 15'(i_data.c) * 15'(i_data.w);
        n_s3.sector   = i_data.sector;
        n_s3.prod     = cw_prod[13:0];
        n_s3.c        = i_data.c;
        n_s3.m        = i_data.m;

        // Division by 60 as a multiply by the scaled reciprocal.
        q_prod        = 29'(r_s3.prod) * 29'(RECIP_60);
        n_s4.sector   = r_s3.sector;
        n_s4.x        = q_prod[RECIP_SHFT +: 9];
        n_s4.c        = r_s3.c;
        n_s4.m        = r_s3.m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
        end else if (i_en) begin
            r_valid3 <= i_valid;
            r_valid4 <= r_valid3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_valid4;
    assign o_data  = r_s4;

endmodule

FILE: hdl/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Last stage: places C and X on the channels by sector and adds the offset.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_s4        i_data,
    output logic       o_valid,
    output logic [8:0] o_red,
    output logic [8:0] o_green,
    output logic [8:0] o_blue
);

    logic       r_valid;
    logic [8:0] r_red;
    logic [8:0] r_green;
    logic [8:0] r_blue;
    logic [8:0] n_red;
    logic [8:0] n_green;
    logic [8:0] n_blue;
    logic [8:0] pr;
    logic [8:0] pg;
    logic [8:0] pb;

    always_comb begin
        case (i_data.sector)
            SEC_RED_YEL: begin
                pr = i_data.c; pg = i_data.x; pb = 9'd0;
            end
            SEC_YEL_GRN: begin
                pr = i_data.x; pg = i_data.c; pb = 9'd0;
            end
            SEC_GRN_CYN: begin
                pr = 9'd0; pg = i_data.c; pb = i_data.x;
            end
            SEC_CYN_BLU: begin
                pr = 9'd0; pg = i_data.x; pb = i_data.c;
            end
            SEC_BLU_MAG: begin
                pr = i_data.x; pg = 9'd0; pb = i_data.c;
            end
            default: begin
                pr = i_data.c; pg = 9'd0; pb = i_data.x;
            end
        endcase
        n_red   = pr + i_data.m;
        n_green = pg + i_data.m;
        n_blue  = pb + i_data.m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

FILE: hdl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to RGB color conversion, five-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while o_stall is low and returns one RGB
// beat for each HSV beat, in order. Stages: input clamp with hue-to-degree and
// chroma multiplies, sector and offset, chroma times weight, multiply by the
// reciprocal of 60, and channel placement with offset add into the output
// register. The pipeline moves as one unit: it holds only while a finished
// result waits under i_stall. An empty output register still lets new beats in
// under i_stall, but bubbles in the earlier stages are not squeezed out while
// the pipeline holds.
`include "assert_macros.svh"

module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [16:0] i_hue_turn,
    input  logic [8:0]  i_saturation,
    input  logic [8:0]  i_brightness,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_red,
    output logic [8:0]  o_green,
    output logic [8:0]  o_blue
);

    logic en;
    logic v1;
    logic v2;
    logic v4;
    t_s1  d1;
    t_s2  d2;
    t_s4  d4;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    hsv2rgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_hue_turn   (i_hue_turn),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (v1),
        .o_data       (d1)
    );

    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    hsv2rgb_xdiv u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_data  (d2),
        .o_valid (v4),
        .o_data  (d4)
    );

    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v4),
        .i_data  (d4),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // The pipeline only holds for a result that is actually waiting.
    `HSV_ASSERT_ALWAYS(a_stall_has_result, i_clk, o_stall |-> o_valid, "stall without result")

    // A beat accepted into a free-running pipeline reaches the output.
    `HSV_ASSERT(a_latency, i_clk, i_rst_n, (i_valid && en ##1 en [*4]) |=> o_valid, "beat lost")

    // Every channel stays within Q1.8 full scale.
    `HSV_ASSERT(a_range, i_clk, i_rst_n, o_valid |-> (o_red <= Q8_ONE && o_green <= Q8_ONE && o_blue <= Q8_ONE), "channel above full scale")

endmodule
